@@ rtl/assert_macros.svh @@
// assertion macros used by the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ASSERT_SAME(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/iefr_pkg.sv @@
// shared types and constants for the icmp echo reply filter
`timescale 1ns / 1ps

package iefr_pkg;

  localparam logic [15:0] POS_MAX = 16'hFFFF;

  typedef enum logic [2:0] {
    VERDICT_MATCH      = 3'd0,
    VERDICT_NOT_IPV4   = 3'd1,
    VERDICT_WRONG_SRC  = 3'd2,
    VERDICT_TOO_SHORT  = 3'd3,
    VERDICT_NOT_REPLY  = 3'd4,
    VERDICT_BAD_CODE   = 3'd5,
    VERDICT_WRONG_ID   = 3'd6,
    VERDICT_TRUNCATED  = 3'd7
  } verdict_t;

  localparam logic CFG_EXPECTED_SOURCE = 1'b0;
  localparam logic CFG_ECHO_IDENT      = 1'b1;

  typedef struct packed {
    logic [15:0] position;
    logic [3:0]  version;
    logic [3:0]  header_words;
    logic [15:0] total_length;
    logic [7:0]  ttl;
    logic [31:0] source;
    logic [31:0] dest;
    logic [7:0]  msg_type;
    logic [7:0]  msg_code;
    logic [15:0] ident;
    logic [15:0] sequence_num;
  } fields_t;

endpackage

@@ rtl/iefr_capture.sv @@
// per-packet field capture registers and their next-value logic
`timescale 1ns / 1ps

module iefr_capture (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  logic [7:0]        data,
  input  logic              last,
  output iefr_pkg::fields_t fields_next
);

  iefr_pkg::fields_t fields;
  logic [3:0]        hw_eff;
  logic [15:0]       off;
  logic              live;

  always_comb begin
    live   = fields.position != iefr_pkg::POS_MAX;
    hw_eff = (fields.position == 16'd0) ? data[3:0] : fields.header_words;
    off    = {10'd0, hw_eff, 2'b00};
    fields_next = fields;
    fields_next.position = live ? fields.position + 16'd1 : fields.position;
    if (live) begin
      if (fields.position == 16'd0) begin
        fields_next.version      = data[7:4];
        fields_next.header_words = data[3:0];
      end
      if (fields.position == 16'd2)  fields_next.total_length[15:8] = data;
      if (fields.position == 16'd3)  fields_next.total_length[7:0]  = data;
      if (fields.position == 16'd8)  fields_next.ttl                = data;
      if (fields.position == 16'd12) fields_next.source[31:24]      = data;
      if (fields.position == 16'd13) fields_next.source[23:16]      = data;
      if (fields.position == 16'd14) fields_next.source[15:8]       = data;
      if (fields.position == 16'd15) fields_next.source[7:0]        = data;
      if (fields.position == 16'd16) fields_next.dest[31:24]        = data;
      if (fields.position == 16'd17) fields_next.dest[23:16]        = data;
      if (fields.position == 16'd18) fields_next.dest[15:8]         = data;
      if (fields.position == 16'd19) fields_next.dest[7:0]          = data;
      // icmp header sits at header length times four
      if (fields.position == off)          fields_next.msg_type           = data;
      if (fields.position == off + 16'd1)  fields_next.msg_code           = data;
      if (fields.position == off + 16'd4)  fields_next.ident[15:8]        = data;
      if (fields.position == off + 16'd5)  fields_next.ident[7:0]         = data;
      if (fields.position == off + 16'd6)  fields_next.sequence_num[15:8] = data;
      if (fields.position == off + 16'd7)  fields_next.sequence_num[7:0]  = data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fields <= '0;
    end else if (take) begin
      fields <= last ? '0 : fields_next;
    end
  end

endmodule

@@ rtl/icmp_echo_reply_filter.sv @@
// top level: icmp echo reply filter with config registers and result register
// accepts one packet byte per cycle, back to back, unless a pending result is stalled
// the verdict for a packet appears in the cycle after the transfer of its last byte
// a pending result stalls input only while out_ready is low
// throughput is set by the single capture register update per byte
// rst clears the config registers, the capture state and the result valid
`timescale 1ns / 1ps

module icmp_echo_reply_filter (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  packet_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  verdict,
  output logic [15:0] echo_sequence,
  output logic [7:0]  time_to_live,
  output logic [31:0] destination_address,
  output logic [15:0] received_length,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  logic [31:0]        expected_source;
  logic [15:0]        echo_ident;
  logic               take;
  iefr_pkg::fields_t  fields_next;
  iefr_pkg::verdict_t verdict_next;
  logic [6:0]         icmp_end;
  logic [6:0]         need;

  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;

  iefr_capture u_capture (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .data        (packet_byte),
    .last        (last_byte),
    .fields_next (fields_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_source <= '0;
      echo_ident      <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        iefr_pkg::CFG_EXPECTED_SOURCE: expected_source <= cfg_data;
        iefr_pkg::CFG_ECHO_IDENT:      echo_ident      <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    icmp_end = {1'b0, fields_next.header_words, 2'b00} + 7'd8;
    need     = (icmp_end > 7'd20) ? icmp_end : 7'd20;
    if (fields_next.version != 4'd4) begin
      verdict_next = iefr_pkg::VERDICT_NOT_IPV4;
    end else if (fields_next.position < {9'd0, need}) begin
      verdict_next = iefr_pkg::VERDICT_TRUNCATED;
    end else if (fields_next.source != expected_source) begin
      verdict_next = iefr_pkg::VERDICT_WRONG_SRC;
    end else if (fields_next.total_length < {9'd0, icmp_end}) begin
      verdict_next = iefr_pkg::VERDICT_TOO_SHORT;
    end else if (fields_next.msg_type != 8'd0) begin
      verdict_next = iefr_pkg::VERDICT_NOT_REPLY;
    end else if (fields_next.msg_code != 8'd0) begin
      verdict_next = iefr_pkg::VERDICT_BAD_CODE;
    end else if (fields_next.ident != echo_ident) begin
      verdict_next = iefr_pkg::VERDICT_WRONG_ID;
    end else begin
      verdict_next = iefr_pkg::VERDICT_MATCH;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take && last_byte) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && last_byte) begin
      verdict             <= verdict_next;
      echo_sequence       <= fields_next.sequence_num;
      time_to_live        <= fields_next.ttl;
      destination_address <= fields_next.dest;
      received_length     <= fields_next.position;
    end
  end

endmodule

@@ rtl/iefr_checker.sv @@
// port-level checks for the icmp echo reply filter, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"

module iefr_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        last_byte,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  verdict,
  input logic [15:0] echo_sequence,
  input logic [7:0]  time_to_live,
  input logic [31:0] destination_address,
  input logic [15:0] received_length
);

  logic        result_pending;
  logic        last_transfer;
  logic        match_out;
  logic [74:0] res_bits;

  assign result_pending = out_valid && !out_ready;
  assign last_transfer  = in_valid && in_ready && last_byte;
  assign match_out      = out_valid && (verdict == iefr_pkg::VERDICT_MATCH);
  assign res_bits       = {verdict, echo_sequence, time_to_live, destination_address,
                           received_length};

  // a stalled result holds its payload
  `ASSERT_NEXT(a_held, clk, rst, result_pending, out_valid && $stable(res_bits), "result changed")
  // last byte transfer always yields a result
  `ASSERT_NEXT(a_last_gives_result, clk, rst, last_transfer, out_valid, "no result after last byte")
  // input backs up only behind a pending result
  `ASSERT_SAME(a_stall_only_when_full, clk, rst, !in_ready, result_pending, "stall without result")
  // every packet has at least one byte
  `ASSERT_SAME(a_length_nonzero, clk, rst, out_valid, received_length != 16'd0, "empty packet result")
  // a match needs a full ipv4 header
  `ASSERT_SAME(a_match_long_enough, clk, rst, match_out, received_length >= 16'd20, "short match")

endmodule

bind icmp_echo_reply_filter iefr_checker u_iefr_checker (.*);

@@ tb/sv/icmp_echo_reply_checker.sv @@
// checker for the icmp echo reply filter: predicts each verdict and compares the results
`timescale 1ns / 1ps

module icmp_echo_reply_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  packet_byte,
  input  logic        last_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  verdict,
  input  logic [15:0] echo_sequence,
  input  logic [7:0]  time_to_live,
  input  logic [31:0] destination_address,
  input  logic [15:0] received_length,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  output int          errors,
  output int          results_pending
);

  typedef struct {
    iefr_pkg::verdict_t verdict;
    logic [15:0]        sequence_num;
    logic [7:0]         ttl;
    logic [31:0]        dest;
    logic [15:0]        length;
  } reply_t;

  reply_t replies_due[$];

  logic [31:0] want_source;
  logic [15:0] want_ident;

  logic [15:0] position;
  logic [3:0]  version_seen;
  logic [3:0]  hdr_words;
  logic [15:0] total_len;
  logic [7:0]  ttl_seen;
  logic [31:0] source_seen;
  logic [31:0] dest_seen;
  logic [7:0]  type_seen;
  logic [7:0]  code_seen;
  logic [15:0] ident_seen;
  logic [15:0] seq_seen;

  task automatic clear_capture();
    position     = '0;
    version_seen = '0;
    hdr_words    = '0;
    total_len    = '0;
    ttl_seen     = '0;
    source_seen  = '0;
    dest_seen    = '0;
    type_seen    = '0;
    code_seen    = '0;
    ident_seen   = '0;
    seq_seen     = '0;
  endtask

  // one byte may feed both an ip header field and an icmp field
  task automatic absorb_byte(input logic [7:0] b);
    int pos;
    int off;
    pos = int'(position);
    if (pos == 0) begin
      version_seen = b[7:4];
      hdr_words    = b[3:0];
    end
    if (pos == 2) total_len[15:8] = b;
    if (pos == 3) total_len[7:0] = b;
    if (pos == 8) ttl_seen = b;
    if (pos >= 12 && pos <= 15) source_seen[(15 - pos) * 8 +: 8] = b;
    if (pos >= 16 && pos <= 19) dest_seen[(19 - pos) * 8 +: 8] = b;
    off = int'(hdr_words) * 4;
    if (pos == off) type_seen = b;
    if (pos == off + 1) code_seen = b;
    if (pos == off + 4) ident_seen[15:8] = b;
    if (pos == off + 5) ident_seen[7:0] = b;
    if (pos == off + 6) seq_seen[15:8] = b;
    if (pos == off + 7) seq_seen[7:0] = b;
  endtask

  function automatic iefr_pkg::verdict_t judge_packet(input int count);
    int icmp_end;
    int need;
    icmp_end = int'(hdr_words) * 4 + 8;
    need = (icmp_end > 20) ? icmp_end : 20;
    if (version_seen != 4'd4) return iefr_pkg::VERDICT_NOT_IPV4;
    if (count < need) return iefr_pkg::VERDICT_TRUNCATED;
    if (source_seen != want_source) return iefr_pkg::VERDICT_WRONG_SRC;
    if (int'(total_len) < icmp_end) return iefr_pkg::VERDICT_TOO_SHORT;
    if (type_seen != 8'd0) return iefr_pkg::VERDICT_NOT_REPLY;
    if (code_seen != 8'd0) return iefr_pkg::VERDICT_BAD_CODE;
    if (ident_seen != want_ident) return iefr_pkg::VERDICT_WRONG_ID;
    return iefr_pkg::VERDICT_MATCH;
  endfunction

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    reply_t want;
    reply_t fresh;
    if (rst) begin
      errors = 0;
      want_source = '0;
      want_ident = '0;
      clear_capture();
      replies_due.delete();
      results_pending = 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          iefr_pkg::CFG_EXPECTED_SOURCE: want_source = cfg_data;
          iefr_pkg::CFG_ECHO_IDENT:      want_ident = cfg_data[15:0];
          default: ;
        endcase
      end

      if (out_valid && out_ready) begin
        if (replies_due.size() == 0) begin
          errors++;
          $display("%0t: result transfer with no verdict expected, got verdict %0d",
                   $time, verdict);
        end else begin
          want = replies_due.pop_front();
          check_field("verdict", 32'(want.verdict), 32'(verdict));
          check_field("echo_sequence", 32'(want.sequence_num), 32'(echo_sequence));
          check_field("time_to_live", 32'(want.ttl), 32'(time_to_live));
          check_field("destination_address", want.dest, destination_address);
          check_field("received_length", 32'(want.length), 32'(received_length));
        end
      end

      if (in_valid && in_ready) begin
        if (position != iefr_pkg::POS_MAX) begin
          absorb_byte(packet_byte);
          position = position + 16'd1;
        end
        if (last_byte) begin
          fresh.verdict      = judge_packet(int'(position));
          fresh.sequence_num = seq_seen;
          fresh.ttl          = ttl_seen;
          fresh.dest         = dest_seen;
          fresh.length       = position;
          replies_due.push_back(fresh);
          clear_capture();
        end
      end

      results_pending = replies_due.size();
    end
  end

endmodule

@@ tb/sv/tb_icmp_echo_reply_filter.sv @@
// testbench top for the icmp echo reply filter: clock, reset, packet stimulus and verdict
`timescale 1ns / 1ps

module tb_icmp_echo_reply_filter;

  localparam int CYCLE_LIMIT = 1_000_000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  packet_byte = '0;
  logic        last_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  verdict;
  logic [15:0] echo_sequence;
  logic [7:0]  time_to_live;
  logic [31:0] destination_address;
  logic [15:0] received_length;
  logic        cfg_write = 1'b0;
  logic        cfg_index = iefr_pkg::CFG_EXPECTED_SOURCE;
  logic [31:0] cfg_data = '0;

  int fail_count;
  int results_pending;
  int cycle_count = 0;
  int send_idle = 23;
  int recv_idle = 49;

  logic [31:0] cur_source = '0;
  logic [15:0] cur_ident = '0;
  logic [7:0]  pkt[$];

  icmp_echo_reply_filter u_top (
    .clk                 (clk),
    .rst                 (rst),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .packet_byte         (packet_byte),
    .last_byte           (last_byte),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .verdict             (verdict),
    .echo_sequence       (echo_sequence),
    .time_to_live        (time_to_live),
    .destination_address (destination_address),
    .received_length     (received_length),
    .cfg_write           (cfg_write),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  icmp_echo_reply_checker u_checker (
    .clk                 (clk),
    .rst                 (rst),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .packet_byte         (packet_byte),
    .last_byte           (last_byte),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .verdict             (verdict),
    .echo_sequence       (echo_sequence),
    .time_to_live        (time_to_live),
    .destination_address (destination_address),
    .received_length     (received_length),
    .cfg_write           (cfg_write),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .errors              (fail_count),
    .results_pending     (results_pending)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic fin);
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    in_valid <= 1'b1;
    packet_byte <= b;
    last_byte <= fin;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_packet();
    int n;
    n = pkt.size();
    for (int i = 0; i < n; i++) send_byte(pkt[i], i == n - 1);
  endtask

  function automatic void put_byte(input int idx, input logic [7:0] b);
    if (idx < pkt.size()) pkt[idx] = b;
  endfunction

  // icmp fields go in first so that the ip header wins where the two overlap
  task automatic build_packet(input logic [3:0] ver, input logic [3:0] hw,
                              input logic [15:0] tlen, input logic [7:0] ttl,
                              input logic [31:0] src, input logic [31:0] dst,
                              input logic [7:0] typ, input logic [7:0] code,
                              input logic [15:0] ident, input logic [15:0] seq,
                              input int len);
    int off;
    pkt.delete();
    for (int i = 0; i < len; i++) pkt.push_back(8'($urandom));
    off = int'(hw) * 4;
    put_byte(off, typ);
    put_byte(off + 1, code);
    put_byte(off + 4, ident[15:8]);
    put_byte(off + 5, ident[7:0]);
    put_byte(off + 6, seq[15:8]);
    put_byte(off + 7, seq[7:0]);
    put_byte(0, {ver, hw});
    put_byte(2, tlen[15:8]);
    put_byte(3, tlen[7:0]);
    put_byte(8, ttl);
    for (int i = 0; i < 4; i++) begin
      put_byte(12 + i, src[31 - 8 * i -: 8]);
      put_byte(16 + i, dst[31 - 8 * i -: 8]);
    end
  endtask

  task automatic write_filter(input logic [31:0] src, input logic [15:0] ident);
    cfg_write <= 1'b1;
    cfg_index <= iefr_pkg::CFG_EXPECTED_SOURCE;
    cfg_data <= src;
    @(posedge clk);
    cfg_index <= iefr_pkg::CFG_ECHO_IDENT;
    cfg_data <= {16'h0000, ident};
    @(posedge clk);
    cfg_write <= 1'b0;
    cur_source = src;
    cur_ident = ident;
  endtask

  task automatic wait_until_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  // mostly well-formed replies with each field disturbed now and then at random, plus noise
  task automatic run_random(input int byte_budget);
    int sent;
    int need;
    int len;
    logic [3:0]  ver;
    logic [3:0]  hw;
    logic [15:0] tlen;
    logic [31:0] src;
    logic [7:0]  typ;
    logic [7:0]  code;
    logic [15:0] ident;
    sent = 0;
    while (sent < byte_budget) begin
      if ($urandom_range(99) < 10) begin
        pkt.delete();
        repeat ($urandom_range(1, 40)) pkt.push_back(8'($urandom));
      end else begin
        ver = ($urandom_range(9) == 0) ? 4'($urandom) : 4'd4;
        hw = ($urandom_range(3) == 0) ? 4'($urandom) : 4'd5;
        need = int'(hw) * 4 + 8;
        if (need < 20) need = 20;
        len = ($urandom_range(7) == 0) ? $urandom_range(1, need - 1)
                                       : need + $urandom_range(0, 12);
        tlen = ($urandom_range(7) == 0) ? 16'($urandom) : 16'(len);
        src = cur_source;
        if ($urandom_range(7) == 0) src[$urandom_range(31)] = ~src[$urandom_range(31)];
        if ($urandom_range(15) == 0) src = $urandom;
        typ = ($urandom_range(7) == 0) ? 8'($urandom) : 8'd0;
        code = ($urandom_range(7) == 0) ? 8'($urandom) : 8'd0;
        ident = ($urandom_range(7) == 0) ? 16'($urandom) : cur_ident;
        build_packet(ver, hw, tlen, 8'($urandom), src, $urandom, typ, code, ident,
                     16'($urandom), len);
      end
      send_packet();
      sent += pkt.size();
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_filter(32'hFFFF_FFFF, 16'hFFFF);
    // directed: extremes and each verdict
    build_packet(4, 5, 28, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 16'hFFFF, 16'hFFFF, 28);
    send_packet();
    build_packet(6, 5, 28, 8'h40, 32'hFFFF_FFFF, 32'h0A00_0001, 0, 0, 16'hFFFF, 1, 28);
    send_packet();
    build_packet(4, 5, 28, 8'h40, 32'h7FFF_FFFF, 32'h0A00_0001, 0, 0, 16'hFFFF, 2, 28);
    send_packet();
    build_packet(4, 5, 27, 8'h40, 32'hFFFF_FFFF, 32'h0A00_0001, 0, 0, 16'hFFFF, 3, 28);
    send_packet();
    build_packet(4, 5, 28, 8'h40, 32'hFFFF_FFFF, 32'h0A00_0001, 8, 0, 16'hFFFF, 4, 28);
    send_packet();
    build_packet(4, 5, 28, 8'h40, 32'hFFFF_FFFF, 32'h0A00_0001, 0, 8'hFF, 16'hFFFF, 5, 28);
    send_packet();
    build_packet(4, 5, 28, 8'h40, 32'hFFFF_FFFF, 32'h0A00_0001, 0, 0, 16'hFFFE, 6, 28);
    send_packet();
    // packets cut short before the source address and inside the icmp header
    build_packet(4, 5, 28, 8'h40, 32'hFFFF_FFFF, 32'h0A00_0001, 0, 0, 16'hFFFF, 7, 12);
    send_packet();
    build_packet(4, 5, 28, 8'h40, 32'hFFFF_FFFF, 32'h0A00_0001, 0, 0, 16'hFFFF, 8, 27);
    send_packet();
    build_packet(4, 5, 28, 8'h40, 32'hFFFF_FFFF, 32'h0A00_0001, 0, 0, 16'hFFFF, 9, 1);
    send_packet();
    // icmp header overlapping the ip header, then the longest ip header and the largest total length
    build_packet(4, 0, 20, 8'h40, 32'hFFFF_FFFF, 32'h0A00_0001, 0, 0, 16'hFFFF, 10, 20);
    send_packet();
    build_packet(4, 2, 20, 8'h40, 32'hFFFF_FFFF, 32'h0A00_0001, 0, 0, 16'hFFFF, 11, 20);
    send_packet();
    build_packet(4, 15, 68, 8'h01, 32'hFFFF_FFFF, 32'hC0A8_0001, 0, 0, 16'hFFFF, 12, 68);
    send_packet();
    build_packet(4, 5, 16'hFFFF, 8'h80, 32'hFFFF_FFFF, 32'h0, 0, 0, 16'hFFFF, 13, 40);
    send_packet();
    wait_until_idle();

    write_filter(32'h0000_0000, 16'h0000);
    build_packet(4, 5, 28, 8'h00, 32'h0, 32'h0, 0, 0, 16'h0000, 16'h0000, 28);
    send_packet();
    wait_until_idle();

    write_filter($urandom, 16'($urandom));
    run_random(370);
    wait_until_idle();

    send_idle = 49;
    recv_idle = 23;
    write_filter($urandom, 16'($urandom));
    run_random(370);
    wait_until_idle();

    send_idle = 0;
    recv_idle = 0;
    write_filter($urandom, 16'($urandom));
    run_random(370);
    wait_until_idle();

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ icmp_echo_reply_filter.f @@
+incdir+rtl
rtl/iefr_pkg.sv
rtl/iefr_capture.sv
rtl/icmp_echo_reply_filter.sv
rtl/iefr_checker.sv
tb/sv/icmp_echo_reply_checker.sv
tb/sv/tb_icmp_echo_reply_filter.sv
